>>> rtl/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared types, constants and the IUPAC base set table for the pileup base
// classifier pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pbc_pkg;

    localparam int COUNT_W = 16;
    localparam int TOTAL_W = 19;
    localparam int SET_SUM_W = 18;
    localparam int INDEL_W = 17;
    localparam int PROD_W = 35;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int N_BASES = 5;

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [2:0]         t_base;
    typedef logic [3:0]         t_ref;
    typedef logic [3:0]         t_set;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISAGREE_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COV      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INDEL_THR    = 2'd2;

    localparam logic [CFG_W-1:0] RST_DISAGREE_THR = 16'd45875;
    localparam logic [CFG_W-1:0] RST_MIN_COV      = 16'd3;
    localparam logic [CFG_W-1:0] RST_INDEL_THR    = 16'd128;

    // base codes
    localparam t_base BASE_A = 3'd0;
    localparam t_base BASE_C = 3'd1;
    localparam t_base BASE_G = 3'd2;
    localparam t_base BASE_T = 3'd3;
    localparam t_base BASE_N = 3'd4;

    // reference codes with an IUPAC meaning
    localparam t_ref REF_M = 4'd5;
    localparam t_ref REF_R = 4'd6;
    localparam t_ref REF_S = 4'd7;
    localparam t_ref REF_V = 4'd8;
    localparam t_ref REF_W = 4'd9;
    localparam t_ref REF_Y = 4'd10;
    localparam t_ref REF_H = 4'd11;
    localparam t_ref REF_K = 4'd12;
    localparam t_ref REF_D = 4'd13;
    localparam t_ref REF_B = 4'd14;

    typedef struct packed {
        logic [TOTAL_W-1:0]   total;
        t_base                top;
        t_count               top_count;
        logic [SET_SUM_W-1:0] set_sum;
        logic [INDEL_W-1:0]   indel;
        t_ref                 ref_code;
    } t_s1;

    typedef struct packed {
        t_s1               s1;
        logic [PROD_W-1:0] thr_prod;
        logic [PROD_W-1:0] ind_prod;
    } t_s2;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        t_base              top;
        t_count             top_count;
        logic               disagree;
        logic               low_coverage;
        logic               high_indel;
    } t_res;

    // base set (bit 0 A, 1 C, 2 G, 3 T); empty for exact codes
    function automatic t_set iupac_set(input t_ref code);
        t_set s;
        unique case (code)
            REF_M:   s = 4'h3;
            REF_R:   s = 4'h5;
            REF_S:   s = 4'h6;
            REF_V:   s = 4'h7;
            REF_W:   s = 4'h9;
            REF_Y:   s = 4'hA;
            REF_H:   s = 4'hB;
            REF_K:   s = 4'hC;
            REF_D:   s = 4'hD;
            REF_B:   s = 4'hE;
            default: s = 4'h0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pbc_sum_max.sv
// ----------------------------------------------------------------------------
// pbc_sum_max
// First stage: coverage total, first maximal base, IUPAC set sum and indel sum.
// ----------------------------------------------------------------------------
`default_nettype none

module pbc_sum_max
    import pbc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_count i_count_a,
    input  wire t_count i_count_c,
    input  wire t_count i_count_g,
    input  wire t_count i_count_t,
    input  wire t_count i_count_n,
    input  wire t_ref   i_ref_code,
    input  wire t_count i_insertions,
    input  wire t_count i_deletions,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_s1         o_data
);

    t_count cnt [N_BASES];
    t_count best;
    t_base  best_idx;
    t_set   set;
    t_s1    n_data;
    t_s1    r_data;
    logic   r_valid;

    assign cnt[0] = i_count_a;
    assign cnt[1] = i_count_c;
    assign cnt[2] = i_count_g;
    assign cnt[3] = i_count_t;
    assign cnt[4] = i_count_n;

    always_comb begin
        best     = cnt[0];
        best_idx = BASE_A;
        for (int i = 1; i < N_BASES; i++) begin
            if (cnt[i] > best) begin
                best     = cnt[i];
                best_idx = t_base'(i);
            end
        end
        set = iupac_set(i_ref_code);
        n_data.total = TOTAL_W'(i_count_a) + TOTAL_W'(i_count_c) + TOTAL_W'(i_count_g)
                     + TOTAL_W'(i_count_t) + TOTAL_W'(i_count_n);
        n_data.top       = best_idx;
        n_data.top_count = best;
        n_data.set_sum   = (set[0] ? SET_SUM_W'(i_count_a) : '0)
                         + (set[1] ? SET_SUM_W'(i_count_c) : '0)
                         + (set[2] ? SET_SUM_W'(i_count_g) : '0)
                         + (set[3] ? SET_SUM_W'(i_count_t) : '0);
        n_data.indel     = INDEL_W'(i_insertions) + INDEL_W'(i_deletions);
        n_data.ref_code  = i_ref_code;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

>>> rtl/pbc_mult.sv
// ----------------------------------------------------------------------------
// pbc_mult
// Second stage: threshold by total products for the ratio tests.
// ----------------------------------------------------------------------------
`default_nettype none

module pbc_mult
    import pbc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CFG_W-1:0] i_disagree_thr,
    input  wire logic [CFG_W-1:0] i_indel_thr,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_s1              i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_s2                   o_data
);

    t_s2  n_data;
    t_s2  r_data;
    logic r_valid;

    always_comb begin
        n_data.s1       = i_data;
        n_data.thr_prod = PROD_W'(i_disagree_thr) * PROD_W'(i_data.total);
        n_data.ind_prod = PROD_W'(i_indel_thr) * PROD_W'(i_data.total);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

>>> rtl/pbc_flags.sv
// ----------------------------------------------------------------------------
// pbc_flags
// Third stage: ratio compares, reference check and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbc_flags
    import pbc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CFG_W-1:0] i_min_cov,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_s2              i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_res                  o_data
);

    t_s1  s1;
    t_set set;
    logic nonzero;
    logic weak_top;
    logic weak_set;
    logic in_set;
    logic dis;
    t_res n_data;
    t_res r_data;
    logic r_valid;

    always_comb begin
        s1       = i_data.s1;
        set      = iupac_set(s1.ref_code);
        nonzero  = s1.total != '0;
        weak_top = nonzero
                && ({3'b0, s1.top_count, 16'b0} <= i_data.thr_prod);
        weak_set = nonzero
                && ({1'b0, s1.set_sum, 16'b0} <= i_data.thr_prod);
        in_set   = (s1.top != BASE_N) && set[s1.top[1:0]];
        if (weak_top) begin
            dis = 1'b1;
        end else if ({1'b0, s1.top} != s1.ref_code) begin
            // empty set: exact code or code fifteen
            if (set != '0) begin
                dis = !in_set || weak_set;
            end else begin
                dis = 1'b1;
            end
        end else begin
            dis = 1'b0;
        end
        n_data.total        = s1.total;
        n_data.top          = s1.top;
        n_data.top_count    = s1.top_count;
        n_data.disagree     = dis;
        n_data.low_coverage = s1.total < TOTAL_W'(i_min_cov);
        n_data.high_indel   = nonzero
                           && ({10'b0, s1.indel, 8'b0} >= i_data.ind_prod);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

>>> rtl/pileup_base_classifier.sv
// ----------------------------------------------------------------------------
// pileup_base_classifier
// Per-position pileup classifier: coverage total, top base and three flags.
// ----------------------------------------------------------------------------
// Takes one position word per cycle and returns one result word per position
// through a three-stage pipeline: sum and maximum search, threshold
// multipliers, then compares and the output
// register. Every stage holds its word under backpressure and accepts a new
// one in the cycle its word moves on, so throughput is one word per cycle
// whenever the output side is ready. Configuration registers are written
// through a plain write port and should only change while the pipeline is
// empty.
// ----------------------------------------------------------------------------
`default_nettype none

module pileup_base_classifier
    import pbc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [15:0]          i_count_a,
    input  wire logic [15:0]          i_count_c,
    input  wire logic [15:0]          i_count_g,
    input  wire logic [15:0]          i_count_t,
    input  wire logic [15:0]          i_count_n,
    input  wire logic [3:0]           i_ref_code,
    input  wire logic [15:0]          i_insertions,
    input  wire logic [15:0]          i_deletions,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [18:0]               o_total_coverage,
    output logic [2:0]                o_top_base,
    output logic [15:0]               o_top_count,
    output logic                      o_disagree,
    output logic                      o_low_coverage,
    output logic                      o_high_indel
);

    logic [CFG_W-1:0] r_disagree_thr;
    logic [CFG_W-1:0] r_min_cov;
    logic [CFG_W-1:0] r_indel_thr;

    logic s1_valid;
    logic s1_ready;
    t_s1  s1_data;
    logic s2_valid;
    logic s2_ready;
    t_s2  s2_data;
    t_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disagree_thr <= RST_DISAGREE_THR;
            r_min_cov      <= RST_MIN_COV;
            r_indel_thr    <= RST_INDEL_THR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DISAGREE_THR: r_disagree_thr <= i_cfg_data;
                REG_MIN_COV:      r_min_cov      <= i_cfg_data;
                REG_INDEL_THR:    r_indel_thr    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pbc_sum_max u_sum_max (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_count_a    (i_count_a),
        .i_count_c    (i_count_c),
        .i_count_g    (i_count_g),
        .i_count_t    (i_count_t),
        .i_count_n    (i_count_n),
        .i_ref_code   (i_ref_code),
        .i_insertions (i_insertions),
        .i_deletions  (i_deletions),
        .o_valid      (s1_valid),
        .i_ready      (s1_ready),
        .o_data       (s1_data)
    );

    pbc_mult u_mult (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_disagree_thr (r_disagree_thr),
        .i_indel_thr    (r_indel_thr),
        .i_valid        (s1_valid),
        .o_ready        (s1_ready),
        .i_data         (s1_data),
        .o_valid        (s2_valid),
        .i_ready        (s2_ready),
        .o_data         (s2_data)
    );

    pbc_flags u_flags (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_min_cov (r_min_cov),
        .i_valid   (s2_valid),
        .o_ready   (s2_ready),
        .i_data    (s2_data),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (res)
    );

    assign o_total_coverage = res.total;
    assign o_top_base       = res.top;
    assign o_top_count      = res.top_count;
    assign o_disagree       = res.disagree;
    assign o_low_coverage   = res.low_coverage;
    assign o_high_indel     = res.high_indel;

endmodule

`default_nettype wire
